// ===== hdl/lpac_pkg.sv =====
package lpac_pkg;

   localparam int POS_W  = 16;
   localparam int CNT_W  = 17;
   localparam int AREA_W = 32;

   typedef enum logic [3:0] {
      A_IDLE,
      A_SWEEP,
      A_WORD,
      A_PREV,
      A_NEXT,
      A_MARK,
      A_GRD,
      A_GUPD,
      A_LRD,
      A_LSCAN,
      A_FIN
   } axis_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_DONE
   } top_state_type;

   typedef struct packed {
      logic ready;
      logic done;
      logic rejected;
   } axis_status_type;

   // highest set bit, binary search
   function automatic logic [5:0] top_bit(input logic [63:0] x);
      logic [63:0] v;
      logic [5:0]  n;
      v = x;
      n = '0;
      if (v[63:32] != '0) begin n[5] = 1'b1; v = v >> 32; end
      if (v[31:16] != '0) begin n[4] = 1'b1; v = v >> 16; end
      if (v[15:8]  != '0) begin n[3] = 1'b1; v = v >> 8;  end
      if (v[7:4]   != '0) begin n[2] = 1'b1; v = v >> 4;  end
      if (v[3:2]   != '0) begin n[1] = 1'b1; v = v >> 2;  end
      if (v[1])           begin n[0] = 1'b1;               end
      return n;
   endfunction

   // lowest set bit, binary search
   function automatic logic [5:0] low_bit(input logic [63:0] x);
      logic [63:0] v;
      logic [5:0]  n;
      v = x;
      n = '0;
      if (v[31:0] == '0) begin n[5] = 1'b1; v = v >> 32; end
      if (v[15:0] == '0) begin n[4] = 1'b1; v = v >> 16; end
      if (v[7:0]  == '0) begin n[3] = 1'b1; v = v >> 8;  end
      if (v[3:0]  == '0) begin n[2] = 1'b1; v = v >> 4;  end
      if (v[1:0]  == '0) begin n[1] = 1'b1; v = v >> 2;  end
      if (!v[0])         begin n[0] = 1'b1;               end
      return n;
   endfunction

endpackage

// ===== hdl/lpac_axis.sv =====
module lpac_axis import lpac_pkg::*; #(
   parameter int AXIS_MAX = 65535
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clr_valid,
   input  logic [POS_W-1:0]     clr_size,
   input  logic                 cmd_valid,
   input  logic [POS_W-1:0]     cmd_pos,
   output axis_status_type      status,
   output logic [POS_W-1:0]     largest
);

   localparam int WORDS     = AXIS_MAX / 64 + 1;
   localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_DEPTH = AXIS_MAX + 1;
   localparam int CNT_AW    = $clog2(CNT_DEPTH);
   localparam logic [WORD_AW-1:0] LAST_W = WORD_AW'(WORDS - 1);

   axis_state_type      st_ff, st_in;
   logic [POS_W-1:0]    size_ff, size_in;
   logic [POS_W-1:0]    largest_ff, largest_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    lo_ff, lo_in;
   logic [POS_W-1:0]    hi_ff, hi_in;
   logic [63:0]         word_ff, word_in;
   logic [WORD_AW-1:0]  scan_ff, scan_in;
   logic [1:0]          k_ff, k_in;
   logic                first_ff, first_in;
   logic                hif_ff, hif_in;
   logic                rej_ff, rej_in;

   // bitmaps of cut marks and of nonzero gap counts, plus the counts
   logic [63:0]         marks_mem [WORDS];
   logic [63:0]         nz_mem    [WORDS];
   logic [CNT_W-1:0]    cnt_mem   [CNT_DEPTH];

   logic [WORD_AW-1:0]  mk_raddr, mk_waddr, nz_raddr, nz_waddr;
   logic [63:0]         mk_rdata_ff, nz_rdata_ff, mk_wdata, nz_wdata;
   logic                mk_we, nz_we, cn_we;
   logic [CNT_AW-1:0]   cn_raddr, cn_waddr;
   logic [CNT_W-1:0]    cn_rdata_ff, cn_wdata;

   logic [POS_W-1:0]    sat_size;
   logic [WORD_AW-1:0]  pw, cw;
   logic [63:0]         bitm, m_lo, m_hi, lword, gmask;
   logic                cmd_bad, hit, lo_here, hi_here, w_first, w_last;
   logic [POS_W-1:0]    gap;
   logic                have;
   logic [CNT_W-1:0]    cnt, cnt_new;

   function automatic logic [POS_W-1:0] wpos(input logic [WORD_AW-1:0] w,
                                             input logic [5:0] b);
      return POS_W'({w, b});
   endfunction

   assign sat_size = (32'(clr_size) > AXIS_MAX) ? POS_W'(AXIS_MAX) : clr_size;
   assign pw       = pos_ff[6 +: WORD_AW];
   assign cw       = cmd_pos[6 +: WORD_AW];
   assign cmd_bad  = (cmd_pos == '0) || (cmd_pos >= size_ff);
   assign bitm     = 64'(1) << pos_ff[5:0];
   assign hit      = (mk_rdata_ff & bitm) != '0;
   assign m_lo     = mk_rdata_ff & (bitm - 64'(1));
   assign m_hi     = mk_rdata_ff & ~((bitm << 1) - 64'(1));
   assign lo_here  = m_lo != '0;
   assign hi_here  = m_hi != '0;
   assign w_first  = pw == '0;
   assign w_last   = pw == LAST_W;
   assign lword    = first_ff
                   ? (nz_rdata_ff & ((64'(2) << largest_ff[5:0]) - 64'(1)))
                   : nz_rdata_ff;

   always_comb begin
      case (k_ff)
         2'd0:    gap = hi_ff - lo_ff;
         2'd1:    gap = pos_ff - lo_ff;
         default: gap = hi_ff - pos_ff;
      endcase
   end

   assign gmask   = 64'(1) << gap[5:0];
   assign have    = (nz_rdata_ff & gmask) != '0;
   assign cnt     = have ? cn_rdata_ff : '0;
   assign cnt_new = (k_ff == 2'd0) ? ((cnt != '0) ? cnt - CNT_W'(1) : '0)
                                   : cnt + CNT_W'(1);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         A_IDLE:  if (cmd_valid) st_in = cmd_bad ? A_FIN : A_WORD;
         A_SWEEP: if (scan_ff == LAST_W) st_in = A_IDLE;
         A_WORD: begin
            if (hit)                          st_in = A_FIN;
            else if (!lo_here && !w_first)    st_in = A_PREV;
            else if (!hi_here && !w_last)     st_in = A_NEXT;
            else                              st_in = A_MARK;
         end
         A_PREV: begin
            if (mk_rdata_ff != '0 || scan_ff == '0)
               st_in = (!hif_ff && !w_last) ? A_NEXT : A_MARK;
         end
         A_NEXT:  if (mk_rdata_ff != '0 || scan_ff == LAST_W) st_in = A_MARK;
         A_MARK:  st_in = A_GRD;
         A_GRD:   st_in = A_GUPD;
         A_GUPD:  st_in = (k_ff == 2'd2) ? A_LRD : A_GRD;
         A_LRD:   st_in = A_LSCAN;
         A_LSCAN: if (lword != '0 || scan_ff == '0) st_in = A_FIN;
         A_FIN:   st_in = A_IDLE;
         default: st_in = A_IDLE;
      endcase
      if (clr_valid) st_in = A_SWEEP;
   end

   // datapath and memory controls
   always_comb begin
      size_in    = size_ff;
      largest_in = largest_ff;
      pos_in     = pos_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      word_in    = word_ff;
      scan_in    = scan_ff;
      k_in       = k_ff;
      first_in   = first_ff;
      hif_in     = hif_ff;
      rej_in     = rej_ff;
      mk_we      = 1'b0;
      mk_waddr   = pw;
      mk_wdata   = word_ff | bitm;
      nz_we      = 1'b0;
      nz_waddr   = gap[6 +: WORD_AW];
      nz_wdata   = (cnt_new != '0) ? (nz_rdata_ff | gmask) : (nz_rdata_ff & ~gmask);
      cn_we      = 1'b0;
      cn_waddr   = gap[CNT_AW-1:0];
      cn_wdata   = cnt_new;
      nz_raddr   = gap[6 +: WORD_AW];
      unique case (st_ff)
         A_IDLE: begin
            if (cmd_valid) begin
               pos_in = cmd_pos;
               rej_in = cmd_bad;
            end
         end
         A_SWEEP: begin
            mk_we    = 1'b1;
            mk_waddr = scan_ff;
            mk_wdata = '0;
            nz_we    = 1'b1;
            nz_waddr = scan_ff;
            nz_wdata = (scan_ff == size_ff[6 +: WORD_AW]) ? (64'(1) << size_ff[5:0]) : '0;
            cn_we    = scan_ff == '0;
            cn_waddr = size_ff[CNT_AW-1:0];
            cn_wdata = CNT_W'(1);
            scan_in  = scan_ff + WORD_AW'(1);
         end
         A_WORD: begin
            rej_in  = hit;
            word_in = mk_rdata_ff;
            hif_in  = hi_here;
            lo_in   = lo_here ? wpos(pw, top_bit(m_lo)) : '0;
            hi_in   = hi_here ? wpos(pw, low_bit(m_hi)) : size_ff;
            if (!lo_here && !w_first)   scan_in = pw - WORD_AW'(1);
            else if (!hi_here && !w_last) scan_in = pw + WORD_AW'(1);
         end
         A_PREV: begin
            if (mk_rdata_ff != '0) lo_in = wpos(scan_ff, top_bit(mk_rdata_ff));
            if (mk_rdata_ff != '0 || scan_ff == '0) scan_in = pw + WORD_AW'(1);
            else scan_in = scan_ff - WORD_AW'(1);
         end
         A_NEXT: begin
            if (mk_rdata_ff != '0) hi_in = wpos(scan_ff, low_bit(mk_rdata_ff));
            else if (scan_ff != LAST_W) scan_in = scan_ff + WORD_AW'(1);
         end
         A_MARK: begin
            mk_we = 1'b1;
            k_in  = 2'd0;
         end
         A_GRD: ;
         A_GUPD: begin
            nz_we = 1'b1;
            cn_we = 1'b1;
            k_in  = k_ff + 2'd1;
         end
         A_LRD: begin
            scan_in  = largest_ff[6 +: WORD_AW];
            nz_raddr = largest_ff[6 +: WORD_AW];
            first_in = 1'b1;
         end
         A_LSCAN: begin
            nz_raddr = scan_ff - WORD_AW'(1);
            first_in = 1'b0;
            if (lword != '0)          largest_in = wpos(scan_ff, top_bit(lword));
            else if (scan_ff == '0)   largest_in = '0;
            else                      scan_in = scan_ff - WORD_AW'(1);
         end
         A_FIN: ;
         default: ;
      endcase
      if (clr_valid) begin
         size_in    = sat_size;
         largest_in = sat_size;
         scan_in    = '0;
      end
   end

   assign mk_raddr = (st_ff == A_IDLE) ? cw : scan_in;
   assign cn_raddr = gap[CNT_AW-1:0];

   always_ff @(posedge clock) begin
      mk_rdata_ff <= marks_mem[mk_raddr];
      if (mk_we) marks_mem[mk_waddr] <= mk_wdata;
   end

   always_ff @(posedge clock) begin
      nz_rdata_ff <= nz_mem[nz_raddr];
      if (nz_we) nz_mem[nz_waddr] <= nz_wdata;
   end

   always_ff @(posedge clock) begin
      cn_rdata_ff <= cnt_mem[cn_raddr];
      if (cn_we) cnt_mem[cn_waddr] <= cn_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= A_SWEEP;
         size_ff    <= POS_W'(AXIS_MAX);
         largest_ff <= POS_W'(AXIS_MAX);
         scan_ff    <= '0;
         k_ff       <= '0;
         first_ff   <= 1'b0;
         hif_ff     <= 1'b0;
         rej_ff     <= 1'b0;
      end else begin
         st_ff      <= st_in;
         size_ff    <= size_in;
         largest_ff <= largest_in;
         scan_ff    <= scan_in;
         k_ff       <= k_in;
         first_ff   <= first_in;
         hif_ff     <= hif_in;
         rej_ff     <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      word_ff <= word_in;
   end

   assign status.ready    = st_ff == A_IDLE;
   assign status.done     = st_ff == A_FIN;
   assign status.rejected = rej_ff;
   assign largest         = largest_ff;

endmodule

// ===== hdl/largest_piece_after_cuts.sv =====
// channel  dir  handshake                 payload
// req      in   req_valid / req_ready     req_func, req_cut_position
// rsp      out  rsp_valid / rsp_ready     rsp_largest_area, rsp_cut_rejected
// csr      in   csr_valid / csr_ready     csr_index, csr_data (always ready)
//
// One item at a time. A cut visits 64-bit bitmap words one by one:
// the neighbor search walks the cut bitmap word by word
// and the largest-gap update walks the nonzero-gap bitmap downward, each on
// one memory read port. Out-of-range cuts skip both walks. Reset and each
// size write start a clearing pass over MAX_SIZE/64+1 bitmap words (1024 by
// default) on that axis; req_ready stays low meanwhile. A waiting result
// does not block the next cut.
module largest_piece_after_cuts import lpac_pkg::*; #(
   parameter int MAX_SIZE = 65535
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [POS_W-1:0]     req_cut_position,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [AREA_W-1:0]    rsp_largest_area,
   output logic                 rsp_cut_rejected,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [POS_W-1:0]     csr_data
);

   // size registers are 16 bits, so an axis never exceeds 65535
   localparam int AXIS_MAX = (MAX_SIZE > 65535) ? 65535 : MAX_SIZE;

   top_state_type        st_ff, st_in;
   logic                 func_ff, func_in;
   logic                 rej_ff, rej_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]    rsp_area_ff, rsp_area_in;
   logic                 rsp_rej_ff, rsp_rej_in;

   axis_status_type      w_stat, h_stat;
   logic [POS_W-1:0]     w_largest, h_largest;
   logic                 accept, rsp_free, sel_done, sel_rej;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign sel_done = func_ff ? h_stat.done : w_stat.done;
   assign sel_rej  = func_ff ? h_stat.rejected : w_stat.rejected;
   assign csr_ready = 1'b1;

   // width axis takes vertical cuts, height axis horizontal ones
   lpac_axis #(.AXIS_MAX(AXIS_MAX)) u_width (
      .clock     (clock),
      .reset     (reset),
      .clr_valid (csr_valid && !csr_index),
      .clr_size  (csr_data),
      .cmd_valid (accept && !req_func),
      .cmd_pos   (req_cut_position),
      .status    (w_stat),
      .largest   (w_largest)
   );

   lpac_axis #(.AXIS_MAX(AXIS_MAX)) u_height (
      .clock     (clock),
      .reset     (reset),
      .clr_valid (csr_valid && csr_index),
      .clr_size  (csr_data),
      .cmd_valid (accept && req_func),
      .cmd_pos   (req_cut_position),
      .status    (h_stat),
      .largest   (h_largest)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         T_IDLE:  if (accept) st_in = T_RUN;
         T_RUN:   if (sel_done) st_in = T_DONE;
         T_DONE:  if (rsp_free) st_in = T_IDLE;
         default: st_in = T_IDLE;
      endcase
   end

   // outputs; the product lands straight in the result register
   always_comb begin
      func_in      = func_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      rsp_rej_in   = rsp_rej_ff;
      req_ready    = 1'b0;
      unique case (st_ff)
         T_IDLE: begin
            req_ready = w_stat.ready && h_stat.ready;
            if (accept) func_in = req_func;
         end
         T_RUN: if (sel_done) rej_in = sel_rej;
         T_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = {16'b0, w_largest} * {16'b0, h_largest};
               rsp_rej_in   = rej_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      rej_ff      <= rej_in;
      rsp_area_ff <= rsp_area_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_area = rsp_area_ff;
   assign rsp_cut_rejected = rsp_rej_ff;

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while one is in flight");

   a_one_axis_done: assert property (@(posedge clock) disable iff (reset)
      !(w_stat.done && h_stat.done))
      else $error("both axes finished at once");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(st_ff) == T_DONE)
      else $error("result raised without a finished item");
`endif

endmodule

// ===== tb/tb_largest_piece_after_cuts.sv =====
module tb_largest_piece_after_cuts import lpac_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // cut direction and register codes
   localparam bit CUT_VERT   = 1'b0;   // splits the width axis
   localparam bit CUT_HORZ   = 1'b1;   // splits the height axis
   localparam bit REG_WIDTH  = 1'b0;
   localparam bit REG_HEIGHT = 1'b1;

   localparam int unsigned FULL_AREA  = 32'hFFFE_0001;  // 65535 * 65535
   localparam int          STALL_LIMIT = 20000;        // cycles with no handshake
   localparam int          ITEMS_PER_PHASE = 175;
   localparam int          NUM_PHASES = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_func;
   logic [POS_W-1:0]     req_cut_position;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [AREA_W-1:0]    rsp_largest_area;
   logic                 rsp_cut_rejected;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_index;
   logic [POS_W-1:0]     csr_data;

   largest_piece_after_cuts u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_cut_position (req_cut_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_largest_area (rsp_largest_area),
      .rsp_cut_rejected (rsp_cut_rejected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Sheet model: per axis the length, the cut marks, a tally of gaps by
   // length and the largest gap. Index 0 is width, 1 is height.
   // ---------------------------------------------------------------------
   int unsigned sheet_len [2];
   int unsigned widest    [2];
   int unsigned gap_tally [2][65536];
   bit          is_cut    [2][65536];
   logic [16:0] cut_log   [$];        // {axis, position} of every live cut

   typedef struct {
      logic [AREA_W-1:0] area;
      logic              rejected;
   } area_result_type;

   area_result_type pending_areas [$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   int  send_idle_pct;
   int  recv_stall_pct;

   function automatic void reset_axis(bit ax, int unsigned len);
      logic [16:0] kept [$];
      for (int i = 0; i < 65536; i++) begin
         gap_tally[ax][i] = 0;
         is_cut[ax][i] = 1'b0;
      end
      foreach (cut_log[i]) begin
         if (cut_log[i][16] != ax) kept.push_back(cut_log[i]);
      end
      cut_log = kept;
      sheet_len[ax] = len;
      widest[ax] = len;
      gap_tally[ax][len] = 1;
   endfunction

   // Apply one cut to the model, return 1 when it is ignored.
   function automatic bit place_cut(bit ax, int unsigned pos);
      int unsigned lo;
      int unsigned hi;
      int unsigned v;
      if (pos == 0 || pos >= sheet_len[ax] || is_cut[ax][pos]) return 1'b1;
      lo = 0;
      hi = sheet_len[ax];
      // nearest neighbors on both sides, sheet edges when none
      foreach (cut_log[i]) begin
         if (cut_log[i][16] == ax) begin
            v = cut_log[i][15:0];
            if (v < pos && v > lo) lo = v;
            if (v > pos && v < hi) hi = v;
         end
      end
      is_cut[ax][pos] = 1'b1;
      cut_log.push_back({ax, pos[15:0]});
      if (gap_tally[ax][hi - lo] > 0) gap_tally[ax][hi - lo]--;
      gap_tally[ax][pos - lo]++;
      gap_tally[ax][hi - pos]++;
      while (widest[ax] > 0 && gap_tally[ax][widest[ax]] == 0) widest[ax]--;
      return 1'b0;
   endfunction

   function automatic area_result_type predict_cut(bit ax, int unsigned pos);
      area_result_type r;
      longint unsigned prod;
      r.rejected = place_cut(ax, pos);
      prod = longint'(widest[0]) * longint'(widest[1]);
      r.area = prod[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed rows. Typed-in results only where obvious: the full-sheet
   // rejects right after reset. Everything else goes to the model.
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic              func;
      logic [15:0]       pos;
      logic              known;
      logic [31:0]       area;
      logic              rejected;
   } cut_row_type;

   localparam int NUM_ROWS = 16;
   cut_row_type directed_cuts [NUM_ROWS] = '{
      '{CUT_VERT, 16'h0000, 1'b1, FULL_AREA, 1'b1},   // edge at zero
      '{CUT_VERT, 16'hFFFF, 1'b1, FULL_AREA, 1'b1},   // at sheet length
      '{CUT_HORZ, 16'h0000, 1'b1, FULL_AREA, 1'b1},
      '{CUT_HORZ, 16'hFFFF, 1'b1, FULL_AREA, 1'b1},
      '{CUT_VERT, 16'h0001, 1'b0, 32'h0,     1'b0},   // first legal position
      '{CUT_VERT, 16'h0001, 1'b0, 32'h0,     1'b0},   // repeat of it
      '{CUT_VERT, 16'hFFFE, 1'b0, 32'h0,     1'b0},   // last legal position
      '{CUT_HORZ, 16'h8000, 1'b0, 32'h0,     1'b0},
      '{CUT_HORZ, 16'h8000, 1'b0, 32'h0,     1'b0},
      '{CUT_HORZ, 16'h7FFF, 1'b0, 32'h0,     1'b0},
      '{CUT_VERT, 16'hAAAA, 1'b0, 32'h0,     1'b0},
      '{CUT_VERT, 16'h5555, 1'b0, 32'h0,     1'b0},
      '{CUT_HORZ, 16'h0001, 1'b0, 32'h0,     1'b0},
      '{CUT_HORZ, 16'hFFFE, 1'b0, 32'h0,     1'b0},
      '{CUT_VERT, 16'h8000, 1'b0, 32'h0,     1'b0},
      '{CUT_HORZ, 16'h4000, 1'b0, 32'h0,     1'b0}
   };

   // sheet sizes per random phase; first phase keeps the reset size
   int unsigned phase_width  [NUM_PHASES] = '{65535, 0, 1, 2, 37, 400, 65535, 1024};
   int unsigned phase_height [NUM_PHASES] = '{65535, 9, 1, 65535, 5, 300, 2, 1024};

   // ---------------------------------------------------------------------
   // Drivers. Called at a falling edge, return at a falling edge. req_valid
   // stays high after an item so back-to-back items never drop it.
   // ---------------------------------------------------------------------
   task automatic send_cut(input bit f, input logic [15:0] pos,
                           input bit known, input area_result_type typed);
      area_result_type exp_r;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_cut_position <= pos;
      do @(posedge clock); while (!req_ready);
      exp_r = predict_cut(f, pos);
      pending_areas.push_back(known ? typed : exp_r);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_areas.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input bit idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      reset_axis(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_position(int unsigned len);
      int          r;
      int unsigned past;
      r = $urandom_range(99);
      past = len + $urandom_range(3);
      if (r < 80 && len >= 2) return 16'($urandom_range(len - 1, 1));
      if (r < 90) begin
         if ($urandom_range(1) == 0 || len >= 65535) return 16'h0;
         return (past > 65535) ? 16'hFFFF : 16'(past);
      end
      return 16'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random stalls at the falling edge, checks at the rising
   // edge against the oldest pending result.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      area_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_areas.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected item area=%0d rejected=%0b",
                        rsp_largest_area, rsp_cut_rejected);
         end else begin
            exp_r = pending_areas.pop_front();
            if (rsp_largest_area !== exp_r.area || rsp_cut_rejected !== exp_r.rejected) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: area exp %0d got %0d, rejected exp %0b got %0b",
                           exp_r.area, rsp_largest_area, exp_r.rejected, rsp_cut_rejected);
            end
         end
      end
   end

   // watchdog: any handshake resets it
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      area_result_type typed;
      bit              ax;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = CUT_VERT;
      req_cut_position = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_WIDTH;
      csr_data         = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      reset_axis(REG_WIDTH, 65535);
      reset_axis(REG_HEIGHT, 65535);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_cuts[i]) begin
         typed.area     = directed_cuts[i].area;
         typed.rejected = directed_cuts[i].rejected;
         send_cut(directed_cuts[i].func, directed_cuts[i].pos,
                  directed_cuts[i].known, typed);
      end
      drain_results();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // idling mix rotates: none, sender idle, receiver stall, both
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         if (ph > 0) begin
            // every cut gives a result, so an empty queue means idle
            repeat (4) @(negedge clock);
            write_size(REG_WIDTH, 16'(phase_width[ph]));
            write_size(REG_HEIGHT, 16'(phase_height[ph]));
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) drain_results();  // sender pause
            ax = 1'($urandom_range(1));
            typed = '{default: '0};
            send_cut(ax, pick_position(sheet_len[ax]), 1'b0, typed);
         end
         drain_results();
      end

      // back to full sheet on both axes once more
      write_size(REG_WIDTH, 16'hFFFF);
      write_size(REG_HEIGHT, 16'hFFFF);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int n = 0; n < 20; n++) begin
         ax = 1'($urandom_range(1));
         send_cut(ax, 16'($urandom), 1'b0, typed);
      end
      drain_results();
      repeat (50) @(negedge clock);

      if (mismatches == 0 && pending_areas.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
